// ----- sv/bmt_pkg.sv -----
package bmt_pkg;

  // Default sizing of the plane store.
  localparam int MaxSideDefault     = 32;
  localparam int ElementBitsDefault = 32;

  // Fixed field widths of the channels.
  localparam int ElementFieldBits = 32;
  localparam int StatusBits       = 3;
  localparam int CfgIndexBits     = 3;
  localparam int CfgDataBits      = 9;

  // Configuration register widths.
  localparam int RankBits  = 3;
  localparam int CountBits = 9;
  localparam int SideBits  = 6;

  // Plane bookkeeping widths.
  localparam int PlanesDoneBits  = 16;
  localparam int PlaneTotalBits  = 17;
  localparam int CountMax        = 256;

  // Supported tensor ranks.
  localparam logic [RankBits-1:0] RankMin   = 3'd2;
  localparam logic [RankBits-1:0] RankThree = 3'd3;
  localparam logic [RankBits-1:0] RankFour  = 3'd4;

  // Register reset values.
  localparam logic [RankBits-1:0]  RankReset    = 3'd2;
  localparam logic [CountBits-1:0] BatchReset   = 9'd1;
  localparam logic [CountBits-1:0] ChannelReset = 9'd1;
  localparam logic [SideBits-1:0]  RowsReset    = 6'd32;
  localparam logic [SideBits-1:0]  ColsReset    = 6'd32;

  // Configuration register indexes.
  typedef enum logic [CfgIndexBits-1:0] {
    RegRank    = 3'd0,
    RegBatch   = 3'd1,
    RegChannel = 3'd2,
    RegRows    = 3'd3,
    RegCols    = 3'd4
  } cfg_reg_e;

  // Result status codes.
  typedef enum logic [StatusBits-1:0] {
    StatusLoaded   = 3'd0,
    StatusElement  = 3'd1,
    StatusDropped  = 3'd2,
    StatusNotReady = 3'd3,
    StatusBadRank  = 3'd4
  } status_e;

  // Result fields other than the element itself.
  typedef struct packed {
    status_e status;
    logic    last_in_plane;
    logic    last_in_tensor;
  } result_meta_t;

endpackage

// ----- sv/bmt_in_if.sv -----
interface bmt_in_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 action;
  logic [bmt_pkg::ElementFieldBits-1:0] element_in;

  modport source (output valid, output action, output element_in, input ready);
  modport sink (input valid, input action, input element_in, output ready);
endinterface

// ----- sv/bmt_out_if.sv -----
interface bmt_out_if;
  logic                                 valid;
  logic                                 ready;
  logic [bmt_pkg::ElementFieldBits-1:0] element_out;
  logic [bmt_pkg::StatusBits-1:0]       status;
  logic                                 last_in_plane;
  logic                                 last_in_tensor;

  modport source (
    output valid, output element_out, output status,
    output last_in_plane, output last_in_tensor, input ready
  );
  modport sink (
    input valid, input element_out, input status,
    input last_in_plane, input last_in_tensor, output ready
  );
endinterface

// ----- sv/bmt_cfg_if.sv -----
interface bmt_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [bmt_pkg::CfgIndexBits-1:0] reg_index;
  logic [bmt_pkg::CfgDataBits-1:0]  data;

  modport source (output valid, output reg_index, output data, input ready);
  modport sink (input valid, input reg_index, input data, output ready);
endinterface

// ----- sv/bmt_ram.sv -----
module bmt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  // One write port and one registered read port; read data holds between reads.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- sv/batched_matrix_transpose.sv -----
// Each result passes through the first stage and the output register. One item per
// cycle is taken unless results stall; each item makes at most one access to the
// plane store, and a two-entry result pipeline takes one more item while a result
// waits. Reset clears all progress counters and the result pipeline and restores
// the register defaults; the plane store is not cleared and needs no start-up pass.
module batched_matrix_transpose #(
  parameter int MAX_SIDE     = bmt_pkg::MaxSideDefault,
  parameter int ELEMENT_BITS = bmt_pkg::ElementBitsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  bmt_in_if.sink      in_i,
  bmt_out_if.source   out_o,
  bmt_cfg_if.sink     cfg_i
);

  localparam int Depth  = MAX_SIDE * MAX_SIDE;
  localparam int AddrW  = $clog2(Depth);
  localparam int CntW   = $clog2(Depth + 1);
  localparam int SideW  = $clog2(MAX_SIDE + 1);
  localparam int TotW   = bmt_pkg::PlaneTotalBits;
  localparam int DoneW  = bmt_pkg::PlanesDoneBits;
  localparam int CntB   = bmt_pkg::CountBits;
  localparam int DataW  = bmt_pkg::ElementFieldBits;

  // Configuration registers.
  logic [bmt_pkg::RankBits-1:0] rank_q;
  logic [CntB-1:0]              batch_q;
  logic [CntB-1:0]              channel_q;
  logic [bmt_pkg::SideBits-1:0] rows_q;
  logic [bmt_pkg::SideBits-1:0] cols_q;
  logic                         cfg_fire;
  logic                         cfg_known;

  // Progress state.
  logic [CntW-1:0]  load_cnt_q, load_cnt_d;
  logic [SideW-1:0] emit_col_q, emit_col_d;
  logic [SideW-1:0] emit_row_q, emit_row_d;
  logic             plane_ready_q, plane_ready_d;
  logic [DoneW-1:0] planes_done_q, planes_done_d;
  logic [AddrW-1:0] rd_addr_q, rd_addr_d;

  // Derived plane geometry.
  logic [SideW-1:0] rows_eff, cols_eff;
  logic [CntB-1:0]  batch_eff, channel_eff;
  logic [CntW-1:0]  plane_size;
  logic [TotW-1:0]  total_planes;

  // Result pipeline.
  logic                  s1_valid_q;
  bmt_pkg::result_meta_t s1_meta_q, meta;
  logic                  s2_valid_q;
  bmt_pkg::result_meta_t s2_meta_q;
  logic [DataW-1:0]      s2_data_q;
  logic                  s2_take, s1_adv, in_ready, in_fire;

  // Store access.
  logic                    wr_en, rd_en;
  logic [ELEMENT_BITS-1:0] rd_data;

  // Register writes are always taken; known indexes abandon the plane in progress.
  assign cfg_i.ready = 1'b1;
  assign cfg_fire    = cfg_i.valid & cfg_i.ready;
  assign cfg_known   = cfg_i.reg_index inside {bmt_pkg::RegRank, bmt_pkg::RegBatch,
                                               bmt_pkg::RegChannel, bmt_pkg::RegRows,
                                               bmt_pkg::RegCols};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rank_q    <= bmt_pkg::RankReset;
      batch_q   <= bmt_pkg::BatchReset;
      channel_q <= bmt_pkg::ChannelReset;
      rows_q    <= bmt_pkg::RowsReset;
      cols_q    <= bmt_pkg::ColsReset;
    end else if (cfg_fire) begin
      case (bmt_pkg::cfg_reg_e'(cfg_i.reg_index))
        bmt_pkg::RegRank:    rank_q    <= cfg_i.data[bmt_pkg::RankBits-1:0];
        bmt_pkg::RegBatch:   batch_q   <= cfg_i.data;
        bmt_pkg::RegChannel: channel_q <= cfg_i.data;
        bmt_pkg::RegRows:    rows_q    <= cfg_i.data[bmt_pkg::SideBits-1:0];
        bmt_pkg::RegCols:    cols_q    <= cfg_i.data[bmt_pkg::SideBits-1:0];
        default: ;
      endcase
    end
  end

  // Saturate plane sides to 1..MAX_SIDE and counts to 1..256.
  always_comb begin
    if (rows_q == '0) begin
      rows_eff = SideW'(1);
    end else if (int'(rows_q) > MAX_SIDE) begin
      rows_eff = SideW'(MAX_SIDE);
    end else begin
      rows_eff = SideW'(rows_q);
    end
    if (cols_q == '0) begin
      cols_eff = SideW'(1);
    end else if (int'(cols_q) > MAX_SIDE) begin
      cols_eff = SideW'(MAX_SIDE);
    end else begin
      cols_eff = SideW'(cols_q);
    end
    if (batch_q == '0) begin
      batch_eff = CntB'(1);
    end else if (int'(batch_q) > bmt_pkg::CountMax) begin
      batch_eff = CntB'(bmt_pkg::CountMax);
    end else begin
      batch_eff = batch_q;
    end
    if (channel_q == '0) begin
      channel_eff = CntB'(1);
    end else if (int'(channel_q) > bmt_pkg::CountMax) begin
      channel_eff = CntB'(bmt_pkg::CountMax);
    end else begin
      channel_eff = channel_q;
    end
  end

  assign plane_size = CntW'(rows_eff) * CntW'(cols_eff);

  // Planes per tensor follow from the rank.
  always_comb begin
    if (rank_q == bmt_pkg::RankFour) begin
      total_planes = TotW'(channel_eff) * TotW'(batch_eff);
    end else if (rank_q == bmt_pkg::RankThree) begin
      total_planes = TotW'(channel_eff);
    end else begin
      total_planes = TotW'(1);
    end
  end

  // Handshake: the first stage moves on whenever the output register can take it.
  assign s2_take    = !s2_valid_q || out_o.ready;
  assign s1_adv     = s1_valid_q && s2_take;
  assign in_ready   = !s1_valid_q || s2_take;
  assign in_i.ready = in_ready;
  assign in_fire    = in_i.valid && in_ready;

  // Decide the result of the transferred item and the next progress state.
  always_comb begin
    meta           = '{status: bmt_pkg::StatusLoaded, last_in_plane: 1'b0,
                       last_in_tensor: 1'b0};
    wr_en          = 1'b0;
    rd_en          = 1'b0;
    load_cnt_d     = load_cnt_q;
    emit_col_d     = emit_col_q;
    emit_row_d     = emit_row_q;
    plane_ready_d  = plane_ready_q;
    planes_done_d  = planes_done_q;
    rd_addr_d      = rd_addr_q;
    if (in_fire) begin
      if (!(rank_q inside {[bmt_pkg::RankMin:bmt_pkg::RankFour]})) begin
        meta.status = bmt_pkg::StatusBadRank;
      end else if (!in_i.action) begin
        if (plane_ready_q) begin
          meta.status = bmt_pkg::StatusDropped;
        end else begin
          wr_en = 1'b1;
          if (load_cnt_q + CntW'(1) >= plane_size) begin
            load_cnt_d    = '0;
            plane_ready_d = 1'b1;
            emit_col_d    = '0;
            emit_row_d    = '0;
            rd_addr_d     = '0;
          end else begin
            load_cnt_d = load_cnt_q + CntW'(1);
          end
        end
      end else if (!plane_ready_q) begin
        meta.status = bmt_pkg::StatusNotReady;
      end else begin
        // Walk down a stored column, then step to the next one.
        meta.status = bmt_pkg::StatusElement;
        rd_en       = 1'b1;
        if (emit_col_q + SideW'(1) >= rows_eff) begin
          emit_col_d = '0;
          if (emit_row_q + SideW'(1) >= cols_eff) begin
            emit_row_d         = '0;
            rd_addr_d          = '0;
            plane_ready_d      = 1'b0;
            meta.last_in_plane = 1'b1;
            if (TotW'(planes_done_q) + TotW'(1) >= total_planes) begin
              planes_done_d       = '0;
              meta.last_in_tensor = 1'b1;
            end else begin
              planes_done_d = planes_done_q + DoneW'(1);
            end
          end else begin
            emit_row_d = emit_row_q + SideW'(1);
            rd_addr_d  = AddrW'(emit_row_q + SideW'(1));
          end
        end else begin
          emit_col_d = emit_col_q + SideW'(1);
          rd_addr_d  = rd_addr_q + AddrW'(cols_eff);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_cnt_q    <= '0;
      emit_col_q    <= '0;
      emit_row_q    <= '0;
      plane_ready_q <= 1'b0;
      planes_done_q <= '0;
      rd_addr_q     <= '0;
    end else if (cfg_fire && cfg_known) begin
      load_cnt_q    <= '0;
      emit_col_q    <= '0;
      emit_row_q    <= '0;
      plane_ready_q <= 1'b0;
      planes_done_q <= '0;
      rd_addr_q     <= '0;
    end else begin
      load_cnt_q    <= load_cnt_d;
      emit_col_q    <= emit_col_d;
      emit_row_q    <= emit_row_d;
      plane_ready_q <= plane_ready_d;
      planes_done_q <= planes_done_d;
      rd_addr_q     <= rd_addr_d;
    end
  end

  // Plane store; its read data holds while the first stage is stalled.
  bmt_ram #(
    .WIDTH (ELEMENT_BITS),
    .DEPTH (Depth)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (load_cnt_q[AddrW-1:0]),
    .wr_data_i (ELEMENT_BITS'(in_i.element_in)),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr_q),
    .rd_data_o (rd_data)
  );

  // Pipeline valid flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_q <= in_fire;
      end
      if (s2_take) begin
        s2_valid_q <= s1_valid_q;
      end
    end
  end

  // Pipeline payload.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_meta_q <= meta;
    end
    if (s1_adv) begin
      s2_meta_q <= s1_meta_q;
      s2_data_q <= (s1_meta_q.status == bmt_pkg::StatusElement) ?
                   DataW'(rd_data) : '0;
    end
  end

  assign out_o.valid          = s2_valid_q;
  assign out_o.element_out    = s2_data_q;
  assign out_o.status         = s2_meta_q.status;
  assign out_o.last_in_plane  = s2_meta_q.last_in_plane;
  assign out_o.last_in_tensor = s2_meta_q.last_in_tensor;

endmodule

// ----- bench/bmt_bench_pkg.sv -----
`timescale 1ns / 1ps

package bmt_bench_pkg;

  // Kinds of item on the input channel.
  typedef enum logic {
    ActLoad  = 1'b0,
    ActFetch = 1'b1
  } action_e;

endpackage

// ----- bench/bmt_result_checker.sv -----
`timescale 1ns / 1ps

module bmt_result_checker
  import bmt_pkg::*;
  import bmt_bench_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  bmt_in_if    in_i,
  bmt_out_if   res_i,
  bmt_cfg_if   cfg_i,
  output int   fail_count_o,
  output int   pending_o
);

  localparam int StoreDepth = MaxSideDefault * MaxSideDefault;

  // One result as the block should return it.
  typedef struct packed {
    logic [ElementFieldBits-1:0] element;
    status_e                     status;
    logic                        last_in_plane;
    logic                        last_in_tensor;
  } plane_result_t;

  // Shadow of the plane store and of the transpose progress.
  logic [ElementBitsDefault-1:0] shadow_plane [StoreDepth];
  int unsigned                   loaded;
  int unsigned                   out_row;
  int unsigned                   out_col;
  int unsigned                   planes_fetched;
  bit                            plane_full;

  // Shadow of the configuration registers.
  logic [RankBits-1:0]  rank_q;
  logic [CountBits-1:0] batch_q;
  logic [CountBits-1:0] channel_q;
  logic [SideBits-1:0]  rows_q;
  logic [SideBits-1:0]  cols_q;

  plane_result_t expected_q [$];
  int            mismatches;
  int            outstanding;

  assign fail_count_o = mismatches;
  assign pending_o    = outstanding;

  function automatic int unsigned side_of(logic [SideBits-1:0] v);
    if (v == 0) return 1;
    return (v > MaxSideDefault) ? MaxSideDefault : v;
  endfunction

  function automatic int unsigned count_of(logic [CountBits-1:0] v);
    if (v == 0) return 1;
    return (v > CountMax) ? CountMax : v;
  endfunction

  function automatic void clear_progress();
    loaded         = 0;
    out_row        = 0;
    out_col        = 0;
    plane_full     = 1'b0;
    planes_fetched = 0;
  endfunction

  // Works out the result of one item and advances the shadow state.
  function automatic plane_result_t predict_transfer(action_e act,
                                                     logic [ElementFieldBits-1:0] value);
    plane_result_t res;
    int unsigned   rows;
    int unsigned   cols;
    int unsigned   planes;
    int unsigned   slot;
    res  = '0;
    rows = side_of(rows_q);
    cols = side_of(cols_q);
    if (rank_q < RankMin || rank_q > RankFour) begin
      res.status = StatusBadRank;
      return res;
    end
    if (act == ActLoad) begin
      if (plane_full) begin
        res.status = StatusDropped;
        return res;
      end
      shadow_plane[loaded % StoreDepth] = value[ElementBitsDefault-1:0];
      loaded++;
      if (loaded >= rows * cols) begin
        loaded     = 0;
        plane_full = 1'b1;
        out_row    = 0;
        out_col    = 0;
      end
      res.status = StatusLoaded;
      return res;
    end
    if (!plane_full) begin
      res.status = StatusNotReady;
      return res;
    end
    // The transposed plane has cols rows and rows columns.
    slot        = (out_col * cols + out_row) % StoreDepth;
    res.element = shadow_plane[slot];
    res.status  = StatusElement;
    out_col++;
    if (out_col >= rows) begin
      out_col = 0;
      out_row++;
      if (out_row >= cols) begin
        out_row           = 0;
        plane_full        = 1'b0;
        res.last_in_plane = 1'b1;
        planes_fetched++;
        if (rank_q == RankThree) begin
          planes = count_of(channel_q);
        end else if (rank_q == RankFour) begin
          planes = count_of(channel_q) * count_of(batch_q);
        end else begin
          planes = 1;
        end
        if (planes_fetched >= planes) begin
          planes_fetched     = 0;
          res.last_in_tensor = 1'b1;
        end
      end
    end
    return res;
  endfunction

  // Results are checked before new items are predicted, so a result can
  // never be matched against an item from the same edge.
  always @(posedge clk_i or negedge rst_ni) begin
    plane_result_t want;
    if (!rst_ni) begin
      expected_q.delete();
      clear_progress();
      rank_q      = RankReset;
      batch_q     = BatchReset;
      channel_q   = ChannelReset;
      rows_q      = RowsReset;
      cols_q      = ColsReset;
      mismatches  = 0;
      outstanding = 0;
    end else begin
      if (res_i.valid && res_i.ready) begin
        if (expected_q.size() == 0) begin
          if (mismatches < 10) begin
            $display("unexpected result at %0t: element %h status %0d",
                     $realtime, res_i.element_out, res_i.status);
          end
          mismatches++;
        end else begin
          want = expected_q.pop_front();
          if (res_i.element_out !== want.element || res_i.status !== want.status ||
              res_i.last_in_plane !== want.last_in_plane ||
              res_i.last_in_tensor !== want.last_in_tensor) begin
            if (mismatches < 10) begin
              $display({"result mismatch at %0t: expected element %h status %0d ",
                        "plane end %b tensor end %b, got element %h status %0d ",
                        "plane end %b tensor end %b"},
                       $realtime, want.element, want.status, want.last_in_plane,
                       want.last_in_tensor, res_i.element_out, res_i.status,
                       res_i.last_in_plane, res_i.last_in_tensor);
            end
            mismatches++;
          end
        end
      end

      // A write to a known register abandons any plane in progress.
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.reg_index)
          RegRank:    rank_q    = cfg_i.data[RankBits-1:0];
          RegBatch:   batch_q   = cfg_i.data[CountBits-1:0];
          RegChannel: channel_q = cfg_i.data[CountBits-1:0];
          RegRows:    rows_q    = cfg_i.data[SideBits-1:0];
          RegCols:    cols_q    = cfg_i.data[SideBits-1:0];
          default: ;
        endcase
        if (cfg_i.reg_index <= RegCols) clear_progress();
      end

      if (in_i.valid && in_i.ready) begin
        expected_q.push_back(predict_transfer(action_e'(in_i.action), in_i.element_in));
      end
      outstanding = expected_q.size();
    end
  end

endmodule

// ----- bench/batched_matrix_transpose_tb.sv -----
`timescale 1ns / 1ps

module batched_matrix_transpose_tb;
  import bmt_pkg::*;
  import bmt_bench_pkg::*;

  localparam int RandomTarget = 640;

  logic clk_i;
  logic rst_ni;
  int   fail_count;
  int   pending;

  // Values last written to each register, as the stimulus plans with them.
  logic [CfgDataBits-1:0] rank_set;
  logic [CfgDataBits-1:0] batch_set;
  logic [CfgDataBits-1:0] channel_set;
  logic [CfgDataBits-1:0] rows_set;
  logic [CfgDataBits-1:0] cols_set;

  int unsigned random_items;
  bit          steady;

  bmt_in_if  in_if ();
  bmt_out_if out_if ();
  bmt_cfg_if cfg_if ();

  batched_matrix_transpose dut (
    .clk_i,
    .rst_ni,
    .in_i  (in_if),
    .out_o (out_if),
    .cfg_i (cfg_if)
  );

  bmt_result_checker result_check (
    .clk_i,
    .rst_ni,
    .in_i         (in_if),
    .res_i        (out_if),
    .cfg_i        (cfg_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // The result side stalls at random, except during the steady stretch.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= steady || ($urandom_range(0, 99) >= 23);
    end
  end

  function automatic int unsigned side_len(logic [CfgDataBits-1:0] raw);
    logic [SideBits-1:0] v;
    v = raw[SideBits-1:0];
    if (v == 0) return 1;
    return (v > MaxSideDefault) ? MaxSideDefault : v;
  endfunction

  function automatic int unsigned count_len(logic [CfgDataBits-1:0] raw);
    if (raw == 0) return 1;
    return (raw > CountMax) ? CountMax : raw;
  endfunction

  // Mostly small sides, with zero, the maximum and oversized values mixed in.
  function automatic logic [CfgDataBits-1:0] pick_side();
    case ($urandom_range(0, 19))
      0:       return '0;
      1:       return CfgDataBits'(MaxSideDefault);
      2:       return CfgDataBits'($urandom_range(33, 63));
      3:       return CfgDataBits'($urandom_range(0, 511));
      default: return CfgDataBits'($urandom_range(1, 6));
    endcase
  endfunction

  function automatic logic [CfgDataBits-1:0] pick_count();
    case ($urandom_range(0, 19))
      0:       return '0;
      1:       return CfgDataBits'(CountMax);
      2:       return '1;
      3:       return CfgDataBits'($urandom_range(0, 511));
      default: return CfgDataBits'($urandom_range(1, 3));
    endcase
  endfunction

  // Offers one item and returns at the edge where it is transferred.
  task automatic send_item(action_e act, logic [ElementFieldBits-1:0] value);
    while (!steady && $urandom_range(0, 99) < 23) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.action     <= act;
    in_if.element_in <= value;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
  endtask

  task automatic send_counted(action_e act);
    steady = random_items >= 200 && random_items < 450;
    send_item(act, $urandom());
    random_items++;
  endtask

  // Holds off the input until every outstanding result has been seen.
  task automatic drain();
    in_if.valid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    @(posedge clk_i);
  endtask

  // The caller lowers valid after the last write of a group.
  task automatic write_reg(cfg_reg_e idx, logic [CfgDataBits-1:0] value);
    cfg_if.valid     <= 1'b1;
    cfg_if.reg_index <= idx;
    cfg_if.data      <= value;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    case (idx)
      RegRank:    rank_set    = value;
      RegBatch:   batch_set   = value;
      RegChannel: channel_set = value;
      RegRows:    rows_set    = value;
      RegCols:    cols_set    = value;
      default: ;
    endcase
  endtask

  // One random setting followed by whole planes loaded and fetched, with
  // stray loads and fetches in between; some runs stop partway through.
  task automatic random_phase();
    int unsigned             plane_len;
    int unsigned             planes;
    int unsigned             rounds;
    int unsigned             stop_at;
    logic [RankBits-1:0]     rank;
    bit                      wrote;
    drain();
    wrote = 1'b0;
    if ($urandom_range(0, 1)) begin
      write_reg(RegRank, ($urandom_range(0, 9) < 7) ?
                CfgDataBits'(RankMin + $urandom_range(0, 2)) :
                CfgDataBits'($urandom_range(0, 511)));
      wrote = 1'b1;
    end
    if ($urandom_range(0, 2) == 0) begin
      write_reg(RegBatch, pick_count());
      wrote = 1'b1;
    end
    if ($urandom_range(0, 2) == 0) begin
      write_reg(RegChannel, pick_count());
      wrote = 1'b1;
    end
    if ($urandom_range(0, 1)) begin
      write_reg(RegRows, pick_side());
      wrote = 1'b1;
    end
    if (!wrote || $urandom_range(0, 1)) write_reg(RegCols, pick_side());
    cfg_if.valid <= 1'b0;

    rank      = rank_set[RankBits-1:0];
    plane_len = side_len(rows_set) * side_len(cols_set);
    if (rank < RankMin || rank > RankFour) begin
      repeat ($urandom_range(4, 16)) send_counted(action_e'($urandom_range(0, 1)));
      return;
    end
    if (rank == RankThree) begin
      planes = count_len(channel_set);
    end else if (rank == RankFour) begin
      planes = count_len(channel_set) * count_len(batch_set);
    end else begin
      planes = 1;
    end

    // Large planes only get a partial load and a few early fetches here.
    if (plane_len > 96) begin
      repeat ($urandom_range(1, 40)) send_counted(ActLoad);
      repeat ($urandom_range(1, 3)) send_counted(ActFetch);
      return;
    end

    rounds  = (planes <= 4) ? planes + $urandom_range(0, planes) : $urandom_range(1, 3);
    stop_at = ($urandom_range(0, 6) == 0) ?
              random_items + $urandom_range(1, 2 * plane_len * rounds) : '1;
    repeat (rounds) begin
      for (int k = 0; k < plane_len; k++) begin
        if (random_items >= stop_at || random_items >= RandomTarget) return;
        if ($urandom_range(0, 19) == 0) send_counted(ActFetch);
        send_counted(ActLoad);
      end
      if ($urandom_range(0, 3) == 0) send_counted(ActLoad);
      for (int k = 0; k < plane_len; k++) begin
        if (random_items >= stop_at || random_items >= RandomTarget) return;
        if ($urandom_range(0, 19) == 0) send_counted(ActLoad);
        if ($urandom_range(0, 99) == 0) drain();
        send_counted(ActFetch);
      end
      if ($urandom_range(0, 3) == 0) send_counted(ActFetch);
    end
  endtask

  initial begin
    logic [ElementFieldBits-1:0] corners [6];
    corners = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000,
                32'h0000_0001, 32'hA5A5_A5A5, 32'h5A5A_5A5A};
    in_if.valid      = 1'b0;
    in_if.action     = ActLoad;
    in_if.element_in = '0;
    cfg_if.valid     = 1'b0;
    cfg_if.reg_index = RegRank;
    cfg_if.data      = '0;
    rank_set         = RankReset;
    batch_set        = BatchReset;
    channel_set      = ChannelReset;
    rows_set         = RowsReset;
    cols_set         = ColsReset;
    random_items     = 0;
    steady           = 1'b0;
    rst_ni           = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Fetch before anything is loaded, then start a plane that gets abandoned.
    send_item(ActFetch, 32'hFFFF_FFFF);
    send_item(ActLoad, '0);
    send_item(ActLoad, '1);

    // A 2 x 3 plane with corner values, a load while it waits, then the
    // whole transposed plane and one fetch too many.
    drain();
    write_reg(RegRows, 9'd2);
    write_reg(RegCols, 9'd3);
    cfg_if.valid <= 1'b0;
    foreach (corners[i]) send_item(ActLoad, corners[i]);
    send_item(ActLoad, 32'h1234_5678);
    repeat (6) send_item(ActFetch, '0);
    send_item(ActFetch, '0);

    // Unsupported ranks at both ends of the field.
    drain();
    write_reg(RegRank, 9'd0);
    cfg_if.valid <= 1'b0;
    send_item(ActLoad, 32'hDEAD_BEEF);
    send_item(ActFetch, '0);
    drain();
    write_reg(RegRank, 9'd7);
    cfg_if.valid <= 1'b0;
    send_item(ActFetch, '1);

    // A full-size plane fills every store entry; the first two transposed
    // rows read back from across the whole store before it is abandoned.
    drain();
    write_reg(RegRank, CfgDataBits'(RankMin));
    write_reg(RegRows, CfgDataBits'(MaxSideDefault));
    write_reg(RegCols, CfgDataBits'(MaxSideDefault));
    cfg_if.valid <= 1'b0;
    repeat (MaxSideDefault * MaxSideDefault) send_item(ActLoad, $urandom());
    repeat (2 * MaxSideDefault) send_item(ActFetch, $urandom());

    while (random_items < RandomTarget) random_phase();

    drain();
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Hard stop in case the handshakes hang.
  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
